// ===== hdl/llt_pkg.sv =====
// ----------------------------------------------------------------------------
// llt_pkg: shared types and constants of the logic-language tokenizer
// Token kinds, lexer mode codes, character codes, the result-group type that
// travels through the queue, and the character class helpers.
// ----------------------------------------------------------------------------
package llt_pkg;

  // Position counter width default
  localparam int unsigned POSITION_BITS_DEF = 16;

  // Field widths
  localparam int unsigned CH_W   = 8;
  localparam int unsigned KIND_W = 4;
  localparam int unsigned SPAN_W = 16;
  localparam int unsigned MODE_W = 4;

  // Results per byte and queue sizing
  localparam int unsigned MAX_RES     = 3;
  localparam int unsigned CNT_W       = $clog2(MAX_RES + 1);
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Token kinds
  localparam logic [KIND_W-1:0] K_NONE   = 4'd0;
  localparam logic [KIND_W-1:0] K_ATOM   = 4'd1;
  localparam logic [KIND_W-1:0] K_VAR    = 4'd2;
  localparam logic [KIND_W-1:0] K_NUM    = 4'd3;
  localparam logic [KIND_W-1:0] K_LPAREN = 4'd4;
  localparam logic [KIND_W-1:0] K_RPAREN = 4'd5;
  localparam logic [KIND_W-1:0] K_LBRACK = 4'd6;
  localparam logic [KIND_W-1:0] K_RBRACK = 4'd7;
  localparam logic [KIND_W-1:0] K_BAR    = 4'd8;
  localparam logic [KIND_W-1:0] K_COMMA  = 4'd9;
  localparam logic [KIND_W-1:0] K_END    = 4'd10;

  // Lexer modes
  localparam logic [MODE_W-1:0] M_IDLE   = 4'd0;
  localparam logic [MODE_W-1:0] M_LINE   = 4'd1;
  localparam logic [MODE_W-1:0] M_BLOCK  = 4'd2;
  localparam logic [MODE_W-1:0] M_SLASH  = 4'd3;
  localparam logic [MODE_W-1:0] M_DOT    = 4'd4;
  localparam logic [MODE_W-1:0] M_SQUOTE = 4'd5;
  localparam logic [MODE_W-1:0] M_DQUOTE = 4'd6;
  localparam logic [MODE_W-1:0] M_INT    = 4'd7;
  localparam logic [MODE_W-1:0] M_NUMDOT = 4'd8;
  localparam logic [MODE_W-1:0] M_FRAC   = 4'd9;
  localparam logic [MODE_W-1:0] M_VAR    = 4'd10;
  localparam logic [MODE_W-1:0] M_ATOM   = 4'd11;
  localparam logic [MODE_W-1:0] M_SYM    = 4'd12;

  // Character codes
  localparam logic [CH_W-1:0] CH_TAB        = 8'h09;
  localparam logic [CH_W-1:0] CH_LF         = 8'h0A;
  localparam logic [CH_W-1:0] CH_CR         = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE      = 8'h20;
  localparam logic [CH_W-1:0] CH_BANG       = 8'h21;
  localparam logic [CH_W-1:0] CH_DQUOTE     = 8'h22;
  localparam logic [CH_W-1:0] CH_HASH       = 8'h23;
  localparam logic [CH_W-1:0] CH_PERCENT    = 8'h25;
  localparam logic [CH_W-1:0] CH_AMP        = 8'h26;
  localparam logic [CH_W-1:0] CH_SQUOTE     = 8'h27;
  localparam logic [CH_W-1:0] CH_LPAREN     = 8'h28;
  localparam logic [CH_W-1:0] CH_RPAREN     = 8'h29;
  localparam logic [CH_W-1:0] CH_STAR       = 8'h2A;
  localparam logic [CH_W-1:0] CH_PLUS       = 8'h2B;
  localparam logic [CH_W-1:0] CH_COMMA      = 8'h2C;
  localparam logic [CH_W-1:0] CH_MINUS      = 8'h2D;
  localparam logic [CH_W-1:0] CH_DOT        = 8'h2E;
  localparam logic [CH_W-1:0] CH_SLASH      = 8'h2F;
  localparam logic [CH_W-1:0] CH_COLON      = 8'h3A;
  localparam logic [CH_W-1:0] CH_SEMI       = 8'h3B;
  localparam logic [CH_W-1:0] CH_LT         = 8'h3C;
  localparam logic [CH_W-1:0] CH_EQ         = 8'h3D;
  localparam logic [CH_W-1:0] CH_GT         = 8'h3E;
  localparam logic [CH_W-1:0] CH_QMARK      = 8'h3F;
  localparam logic [CH_W-1:0] CH_AT         = 8'h40;
  localparam logic [CH_W-1:0] CH_LBRACK     = 8'h5B;
  localparam logic [CH_W-1:0] CH_BSLASH     = 8'h5C;
  localparam logic [CH_W-1:0] CH_RBRACK     = 8'h5D;
  localparam logic [CH_W-1:0] CH_CARET      = 8'h5E;
  localparam logic [CH_W-1:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [CH_W-1:0] CH_BAR        = 8'h7C;
  localparam logic [CH_W-1:0] CH_TILDE      = 8'h7E;

  // One result item
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SPAN_W-1:0] span_start;
    logic [SPAN_W-1:0] span_end;
    logic              last;
  } tok_t;

  // All results caused by one byte
  typedef struct packed {
    logic [CNT_W-1:0]       cnt;
    tok_t [MAX_RES-1:0]     tok;
  } grp_t;

  // Append one token to a group, drop it when the group is full
  function automatic grp_t grp_push(grp_t g, logic [KIND_W-1:0] kind,
                                    logic [SPAN_W-1:0] s, logic [SPAN_W-1:0] e);
    grp_t r;
    r = g;
    if (g.cnt != CNT_W'(MAX_RES)) begin
      r.tok[g.cnt].kind       = kind;
      r.tok[g.cnt].span_start = s;
      r.tok[g.cnt].span_end   = e;
      r.tok[g.cnt].last       = 1'b0;
      r.cnt                   = g.cnt + 1'b1;
    end
    return r;
  endfunction

  function automatic logic is_layout(logic [CH_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_digit(logic [CH_W-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_upper(logic [CH_W-1:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_lower(logic [CH_W-1:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_alnum(logic [CH_W-1:0] c);
    return is_upper(c) || is_lower(c) || is_digit(c) || (c == CH_UNDERSCORE);
  endfunction

  function automatic logic is_symbol(logic [CH_W-1:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH) ||
           (c == CH_BSLASH) || (c == CH_CARET) || (c == CH_LT) || (c == CH_GT) ||
           (c == CH_EQ) || (c == CH_TILDE) || (c == CH_COLON) || (c == CH_QMARK) ||
           (c == CH_AT) || (c == CH_HASH) || (c == CH_AMP);
  endfunction

endpackage

// ===== hdl/llt_stream_if.sv =====
// ----------------------------------------------------------------------------
// llt_stream_if: valid/ready channels of the tokenizer
// Byte channel into the block and token channel out of it.
// ----------------------------------------------------------------------------
interface llt_in_if;
  logic                      valid;
  logic                      ready;
  logic [llt_pkg::CH_W-1:0]  ch;
  logic                      final_byte;

  modport source (output valid, ch, final_byte, input ready);
  modport sink   (input valid, ch, final_byte, output ready);
endinterface

interface llt_out_if;
  logic                        valid;
  logic                        ready;
  logic [llt_pkg::KIND_W-1:0]  kind;
  logic [llt_pkg::SPAN_W-1:0]  span_start;
  logic [llt_pkg::SPAN_W-1:0]  span_end;
  logic                        last;

  modport source (output valid, kind, span_start, span_end, last, input ready);
  modport sink   (input valid, kind, span_start, span_end, last, output ready);
endinterface

// ===== hdl/llt_front.sv =====
// ----------------------------------------------------------------------------
// llt_front: byte classifier and lexer state
// Accepts one byte per cycle while the queue is not full, advances the lexer
// mode and forms the group of tokens that the byte completes, for the queue.
// ----------------------------------------------------------------------------
module llt_front #(
  parameter int unsigned POSITION_BITS = llt_pkg::POSITION_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  llt_in_if.sink        in_i,
  input  logic          q_full_i,
  output logic          push_o,
  output llt_pkg::grp_t grp_o
);

  localparam logic [POSITION_BITS-1:0] PosMax = '1;

  logic [llt_pkg::MODE_W-1:0] mode_q, mode_d;
  logic [POSITION_BITS-1:0]   start_q, start_d;
  logic [POSITION_BITS-1:0]   pos_q, pos_d;
  logic                       star_q, star_d;

  logic [llt_pkg::CH_W-1:0]   c;
  logic                       fin;
  logic                       accept;
  logic [POSITION_BITS-1:0]   nx;
  logic [POSITION_BITS-1:0]   dotp;
  logic [POSITION_BITS-1:0]   dotp_nx;
  logic                       do_begin;

  logic [llt_pkg::MODE_W-1:0] b_mode;
  logic [POSITION_BITS-1:0]   b_start;
  logic                       b_emit;
  logic [llt_pkg::KIND_W-1:0] b_kind;

  llt_pkg::grp_t              g;

  // Take the low span bits of a position, zero-extended where narrower
  function automatic logic [llt_pkg::SPAN_W-1:0] span(logic [POSITION_BITS-1:0] p);
    logic [POSITION_BITS+llt_pkg::SPAN_W-1:0] w;
    w = {{llt_pkg::SPAN_W{1'b0}}, p};
    return w[llt_pkg::SPAN_W-1:0];
  endfunction

  assign c        = in_i.ch;
  assign fin      = in_i.final_byte;
  assign in_i.ready = ~q_full_i;
  assign accept   = in_i.valid & ~q_full_i;

  // Saturating next position
  assign nx      = (pos_q == PosMax) ? PosMax : pos_q + 1'b1;
  assign dotp    = star_q ? PosMax : pos_q - 1'b1;
  assign dotp_nx = (dotp == PosMax) ? PosMax : dotp + 1'b1;

  // Classify a byte that opens a new token
  always_comb begin
    b_mode  = llt_pkg::M_IDLE;
    b_start = pos_q;
    b_emit  = 1'b0;
    b_kind  = llt_pkg::K_NONE;
    if (!llt_pkg::is_layout(c)) begin
      case (c)
        llt_pkg::CH_PERCENT: b_mode = llt_pkg::M_LINE;
        llt_pkg::CH_SLASH:   b_mode = llt_pkg::M_SLASH;
        llt_pkg::CH_DOT:     b_mode = llt_pkg::M_DOT;
        llt_pkg::CH_LPAREN: begin
          b_emit = 1'b1;
          b_kind = llt_pkg::K_LPAREN;
        end
        llt_pkg::CH_RPAREN: begin
          b_emit = 1'b1;
          b_kind = llt_pkg::K_RPAREN;
        end
        llt_pkg::CH_LBRACK: begin
          b_emit = 1'b1;
          b_kind = llt_pkg::K_LBRACK;
        end
        llt_pkg::CH_RBRACK: begin
          b_emit = 1'b1;
          b_kind = llt_pkg::K_RBRACK;
        end
        llt_pkg::CH_BAR: begin
          b_emit = 1'b1;
          b_kind = llt_pkg::K_BAR;
        end
        llt_pkg::CH_COMMA: begin
          b_emit = 1'b1;
          b_kind = llt_pkg::K_COMMA;
        end
        llt_pkg::CH_BANG, llt_pkg::CH_SEMI: begin
          b_emit = 1'b1;
          b_kind = llt_pkg::K_ATOM;
        end
        llt_pkg::CH_SQUOTE: begin
          b_mode  = llt_pkg::M_SQUOTE;
          b_start = nx;
        end
        llt_pkg::CH_DQUOTE: begin
          b_mode  = llt_pkg::M_DQUOTE;
          b_start = nx;
        end
        default: begin
          if (llt_pkg::is_digit(c)) begin
            b_mode = llt_pkg::M_INT;
          end else if (llt_pkg::is_upper(c) || (c == llt_pkg::CH_UNDERSCORE)) begin
            b_mode = llt_pkg::M_VAR;
          end else if (llt_pkg::is_lower(c)) begin
            b_mode = llt_pkg::M_ATOM;
          end else if (llt_pkg::is_symbol(c)) begin
            b_mode = llt_pkg::M_SYM;
          end
        end
      endcase
    end
  end

  // Advance the mode and collect the tokens this byte completes
  always_comb begin
    mode_d   = mode_q;
    start_d  = start_q;
    star_d   = star_q;
    pos_d    = nx;
    do_begin = 1'b0;
    g        = '0;

    unique case (mode_q)
      llt_pkg::M_LINE: begin
        if (c == llt_pkg::CH_LF) mode_d = llt_pkg::M_IDLE;
      end
      llt_pkg::M_BLOCK: begin
        if ((c == llt_pkg::CH_SLASH) && star_q) begin
          mode_d = llt_pkg::M_IDLE;
          star_d = 1'b0;
        end else begin
          star_d = (c == llt_pkg::CH_STAR);
        end
      end
      llt_pkg::M_SLASH: begin
        if (c == llt_pkg::CH_STAR) begin
          mode_d = llt_pkg::M_BLOCK;
          star_d = 1'b0;
        end else if (llt_pkg::is_symbol(c)) begin
          mode_d = llt_pkg::M_SYM;
        end else begin
          g        = llt_pkg::grp_push(g, llt_pkg::K_ATOM, span(start_q), span(pos_q));
          do_begin = 1'b1;
        end
      end
      llt_pkg::M_DOT: begin
        if (llt_pkg::is_layout(c) || (c == llt_pkg::CH_PERCENT)) begin
          g = llt_pkg::grp_push(g, llt_pkg::K_END, span(start_q), span(pos_q));
        end
        do_begin = 1'b1;
      end
      llt_pkg::M_SQUOTE, llt_pkg::M_DQUOTE: begin
        if (c == ((mode_q == llt_pkg::M_SQUOTE) ? llt_pkg::CH_SQUOTE
                                                : llt_pkg::CH_DQUOTE)) begin
          g      = llt_pkg::grp_push(g, llt_pkg::K_ATOM, span(start_q), span(pos_q));
          mode_d = llt_pkg::M_IDLE;
        end
      end
      llt_pkg::M_INT: begin
        if (c == llt_pkg::CH_DOT) begin
          mode_d = llt_pkg::M_NUMDOT;
          star_d = (pos_q == PosMax);
        end else if (!llt_pkg::is_digit(c)) begin
          g        = llt_pkg::grp_push(g, llt_pkg::K_NUM, span(start_q), span(pos_q));
          do_begin = 1'b1;
        end
      end
      llt_pkg::M_NUMDOT: begin
        star_d = 1'b0;
        if (llt_pkg::is_digit(c)) begin
          mode_d = llt_pkg::M_FRAC;
        end else begin
          // Number ends at the dot, then judge the dot as a full stop
          g = llt_pkg::grp_push(g, llt_pkg::K_NUM, span(start_q), span(dotp));
          if (llt_pkg::is_layout(c) || (c == llt_pkg::CH_PERCENT)) begin
            g = llt_pkg::grp_push(g, llt_pkg::K_END, span(dotp), span(dotp_nx));
          end
          do_begin = 1'b1;
        end
      end
      llt_pkg::M_FRAC: begin
        if (!llt_pkg::is_digit(c)) begin
          g        = llt_pkg::grp_push(g, llt_pkg::K_NUM, span(start_q), span(pos_q));
          do_begin = 1'b1;
        end
      end
      llt_pkg::M_VAR, llt_pkg::M_ATOM: begin
        if (!llt_pkg::is_alnum(c)) begin
          g = llt_pkg::grp_push(g, (mode_q == llt_pkg::M_VAR) ? llt_pkg::K_VAR
                                                              : llt_pkg::K_ATOM,
                                span(start_q), span(pos_q));
          do_begin = 1'b1;
        end
      end
      llt_pkg::M_SYM: begin
        if (!llt_pkg::is_symbol(c)) begin
          g        = llt_pkg::grp_push(g, llt_pkg::K_ATOM, span(start_q), span(pos_q));
          do_begin = 1'b1;
        end
      end
      default: do_begin = 1'b1;
    endcase

    // Open a new token with this byte
    if (do_begin) begin
      mode_d  = b_mode;
      start_d = b_start;
      if (b_emit) g = llt_pkg::grp_push(g, b_kind, span(pos_q), span(nx));
    end

    // Flush any open token at the end of the text, then restart
    if (fin) begin
      case (mode_d)
        llt_pkg::M_SLASH, llt_pkg::M_SQUOTE, llt_pkg::M_DQUOTE, llt_pkg::M_SYM,
        llt_pkg::M_ATOM:
          g = llt_pkg::grp_push(g, llt_pkg::K_ATOM, span(start_d), span(nx));
        llt_pkg::M_VAR:
          g = llt_pkg::grp_push(g, llt_pkg::K_VAR, span(start_d), span(nx));
        llt_pkg::M_INT, llt_pkg::M_FRAC:
          g = llt_pkg::grp_push(g, llt_pkg::K_NUM, span(start_d), span(nx));
        llt_pkg::M_DOT:
          g = llt_pkg::grp_push(g, llt_pkg::K_END, span(start_d), span(nx));
        llt_pkg::M_NUMDOT: begin
          g = llt_pkg::grp_push(g, llt_pkg::K_NUM, span(start_d), span(pos_q));
          g = llt_pkg::grp_push(g, llt_pkg::K_END, span(pos_q), span(nx));
        end
        default: ;
      endcase
      if (g.cnt == '0) begin
        g = llt_pkg::grp_push(g, llt_pkg::K_NONE, '0, '0);
      end
      g.tok[g.cnt - 1'b1].last = 1'b1;
      mode_d  = llt_pkg::M_IDLE;
      start_d = '0;
      pos_d   = '0;
      star_d  = 1'b0;
    end
  end

  assign push_o = accept & (g.cnt != '0);
  assign grp_o  = g;

  // Hold lexer state, advance on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= llt_pkg::M_IDLE;
      start_q <= '0;
      pos_q   <= '0;
      star_q  <= 1'b0;
    end else if (accept) begin
      mode_q  <= mode_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      star_q  <= star_d;
    end
  end

endmodule

// ===== hdl/llt_queue.sv =====
// ----------------------------------------------------------------------------
// llt_queue: short queue of token groups
// Decouples the byte side from the token side; one group per byte that
// produced tokens.
// ----------------------------------------------------------------------------
module llt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  llt_pkg::grp_t grp_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          avail_o,
  output llt_pkg::grp_t head_o
);

  llt_pkg::grp_t                mem_q [llt_pkg::QUEUE_DEPTH];
  logic [llt_pkg::QPTR_W-1:0]   wr_q, rd_q;
  logic [llt_pkg::QCNT_W-1:0]   cnt_q;

  assign full_o  = (cnt_q == llt_pkg::QCNT_W'(llt_pkg::QUEUE_DEPTH));
  assign avail_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  // Store incoming groups
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= grp_i;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== hdl/llt_back.sv =====
// ----------------------------------------------------------------------------
// llt_back: token serialiser and output register
// Walks head-group tokens to the output register one per cycle unless stalled.
// ----------------------------------------------------------------------------
module llt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          avail_i,
  input  llt_pkg::grp_t head_i,
  output logic          pop_o,
  llt_out_if.source     out_o
);

  logic [llt_pkg::CNT_W-1:0] idx_q;
  logic                      valid_q;
  llt_pkg::tok_t             tok_q;
  logic                      load;
  logic                      group_done;

  assign load       = avail_i & (~valid_q | out_o.ready);
  assign group_done = (idx_q == head_i.cnt - 1'b1);
  assign pop_o      = load & group_done;

  // Step through the group, drop it after its last token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q   <= group_done ? '0 : idx_q + 1'b1;
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load) tok_q <= head_i.tok[idx_q];
  end

  assign out_o.valid      = valid_q;
  assign out_o.kind       = tok_q.kind;
  assign out_o.span_start = tok_q.span_start;
  assign out_o.span_end   = tok_q.span_end;
  assign out_o.last       = tok_q.last;

endmodule

// ===== hdl/logic_language_tokenizer.sv =====
// ----------------------------------------------------------------------------
// logic_language_tokenizer: streaming lexer for logic-programming source
// Splits a byte stream into atoms, variables, numbers, punctuation and clause
// ends, each with start and exclusive end offsets.
// ----------------------------------------------------------------------------
//  channel | dir | payload                               | handshake
//  in_i    | in  | ch[7:0], final_byte                   | valid/ready
//  out_o   | out | kind[3:0], span_start, span_end, last | valid/ready
//
//  One byte is accepted per cycle; the lexer mode update is a single step.
//  A byte yields zero to three tokens, grouped and held in a four-entry queue;
//  tokens leave one per cycle through a registered output stage.
//  Input stalls only when the queue is full; output stalls back up the queue.
//  Reset clears mode, positions, queue and output valid; no clearing pass.
module logic_language_tokenizer #(
  parameter int unsigned POSITION_BITS = llt_pkg::POSITION_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  llt_in_if.sink     in_i,
  llt_out_if.source  out_o
);

  logic          push;
  logic          pop;
  logic          full;
  logic          avail;
  llt_pkg::grp_t grp;
  llt_pkg::grp_t head;

  // Classify bytes and track lexer state
  llt_front #(
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (full),
    .push_o   (push),
    .grp_o    (grp)
  );

  // Buffer token groups
  llt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .grp_i   (grp),
    .pop_i   (pop),
    .full_o  (full),
    .avail_o (avail),
    .head_o  (head)
  );

  // Serialise tokens onto the output
  llt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== tb/logic_language_tokenizer_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// logic_language_tokenizer_checker: token predictor and scoreboard
// Watches both channels of the tokenizer. Every accepted source byte is run
// through a local lexer that yields the tokens the byte completes; every
// accepted token is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module logic_language_tokenizer_checker #(
  parameter int unsigned POSITION_BITS = llt_pkg::POSITION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  llt_in_if           in_i,
  llt_out_if          out_i,
  output int unsigned fault_count_o,
  output int unsigned pending_o
);
  import llt_pkg::*;

  localparam logic [31:0] OFFSET_MAX = 32'((64'd1 << POSITION_BITS) - 64'd1);

  // Lexer state of the predictor
  logic [MODE_W-1:0] lex_state;
  logic [31:0]       tok_origin;
  logic [31:0]       next_offset;
  logic              star_flag;

  // Tokens of the current byte, and tokens still due on the output
  tok_t byte_tokens[$];
  tok_t expected_tokens[$];

  function automatic logic [31:0] bump(logic [31:0] p);
    return (p >= OFFSET_MAX) ? OFFSET_MAX : p + 32'd1;
  endfunction

  function automatic logic blank_ch(logic [CH_W-1:0] c);
    case (c)
      CH_SPACE, CH_TAB, CH_CR, CH_LF: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic digit_ch(logic [CH_W-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic upper_ch(logic [CH_W-1:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic lower_ch(logic [CH_W-1:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic word_ch(logic [CH_W-1:0] c);
    return upper_ch(c) || lower_ch(c) || digit_ch(c) || (c == CH_UNDERSCORE);
  endfunction

  function automatic logic symbol_ch(logic [CH_W-1:0] c);
    case (c)
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_BSLASH, CH_CARET, CH_LT, CH_GT,
      CH_EQ, CH_TILDE, CH_COLON, CH_QMARK, CH_AT, CH_HASH, CH_AMP: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Record one token for this byte; at most three fit
  function automatic void add_token(logic [KIND_W-1:0] kind, logic [31:0] s,
                                    logic [31:0] e);
    tok_t t;
    if (byte_tokens.size() < MAX_RES) begin
      t.kind       = kind;
      t.span_start = s[SPAN_W-1:0];
      t.span_end   = e[SPAN_W-1:0];
      t.last       = 1'b0;
      byte_tokens.push_back(t);
    end
  endfunction

  // Judge a byte that arrives with no token open
  function automatic void open_token(logic [CH_W-1:0] c, logic [31:0] pos);
    logic [31:0] nxt;
    nxt        = bump(pos);
    lex_state  = M_IDLE;
    tok_origin = pos;
    if (!blank_ch(c)) begin
      case (c)
        CH_PERCENT: lex_state = M_LINE;
        CH_SLASH:   lex_state = M_SLASH;
        CH_DOT:     lex_state = M_DOT;
        CH_LPAREN:  add_token(K_LPAREN, pos, nxt);
        CH_RPAREN:  add_token(K_RPAREN, pos, nxt);
        CH_LBRACK:  add_token(K_LBRACK, pos, nxt);
        CH_RBRACK:  add_token(K_RBRACK, pos, nxt);
        CH_BAR:     add_token(K_BAR, pos, nxt);
        CH_COMMA:   add_token(K_COMMA, pos, nxt);
        CH_BANG, CH_SEMI: add_token(K_ATOM, pos, nxt);
        CH_SQUOTE: begin
          lex_state  = M_SQUOTE;
          tok_origin = nxt;
        end
        CH_DQUOTE: begin
          lex_state  = M_DQUOTE;
          tok_origin = nxt;
        end
        default: begin
          if (digit_ch(c)) lex_state = M_INT;
          else if (upper_ch(c) || c == CH_UNDERSCORE) lex_state = M_VAR;
          else if (lower_ch(c)) lex_state = M_ATOM;
          else if (symbol_ch(c)) lex_state = M_SYM;
        end
      endcase
    end
  endfunction

  // Advance the lexer by one byte and queue the tokens it completes
  function automatic void lex_byte(logic [CH_W-1:0] c, logic fin);
    logic [31:0] pos;
    logic [31:0] nxt;
    logic [31:0] dot_at;
    tok_t        t;
    pos = next_offset;
    nxt = bump(pos);
    byte_tokens.delete();
    case (lex_state)
      M_LINE: if (c == CH_LF) lex_state = M_IDLE;
      M_BLOCK: begin
        if (c == CH_SLASH && star_flag) begin
          lex_state = M_IDLE;
          star_flag = 1'b0;
        end else begin
          star_flag = (c == CH_STAR);
        end
      end
      M_SLASH: begin
        if (c == CH_STAR) begin
          lex_state = M_BLOCK;
          star_flag = 1'b0;
        end else if (symbol_ch(c)) begin
          lex_state = M_SYM;
        end else begin
          add_token(K_ATOM, tok_origin, pos);
          open_token(c, pos);
        end
      end
      M_DOT: begin
        if (blank_ch(c) || c == CH_PERCENT) add_token(K_END, tok_origin, pos);
        open_token(c, pos);
      end
      M_SQUOTE: begin
        if (c == CH_SQUOTE) begin
          add_token(K_ATOM, tok_origin, pos);
          lex_state = M_IDLE;
        end
      end
      M_DQUOTE: begin
        if (c == CH_DQUOTE) begin
          add_token(K_ATOM, tok_origin, pos);
          lex_state = M_IDLE;
        end
      end
      M_INT: begin
        if (c == CH_DOT) begin
          lex_state = M_NUMDOT;
          star_flag = (pos == OFFSET_MAX);
        end else if (!digit_ch(c)) begin
          add_token(K_NUM, tok_origin, pos);
          open_token(c, pos);
        end
      end
      M_NUMDOT: begin
        if (digit_ch(c)) begin
          lex_state = M_FRAC;
          star_flag = 1'b0;
        end else begin
          // The number ends at its dot; the dot may still close the clause
          dot_at    = star_flag ? OFFSET_MAX : pos - 32'd1;
          star_flag = 1'b0;
          add_token(K_NUM, tok_origin, dot_at);
          if (blank_ch(c) || c == CH_PERCENT) add_token(K_END, dot_at, bump(dot_at));
          open_token(c, pos);
        end
      end
      M_FRAC: begin
        if (!digit_ch(c)) begin
          add_token(K_NUM, tok_origin, pos);
          open_token(c, pos);
        end
      end
      M_VAR, M_ATOM: begin
        if (!word_ch(c)) begin
          add_token((lex_state == M_VAR) ? K_VAR : K_ATOM, tok_origin, pos);
          open_token(c, pos);
        end
      end
      M_SYM: begin
        if (!symbol_ch(c)) begin
          add_token(K_ATOM, tok_origin, pos);
          open_token(c, pos);
        end
      end
      default: open_token(c, pos);
    endcase

    if (fin) begin
      // Close whatever is open at the end of the text
      case (lex_state)
        M_SLASH, M_SQUOTE, M_DQUOTE, M_SYM, M_ATOM: add_token(K_ATOM, tok_origin, nxt);
        M_VAR:         add_token(K_VAR, tok_origin, nxt);
        M_INT, M_FRAC: add_token(K_NUM, tok_origin, nxt);
        M_DOT:         add_token(K_END, tok_origin, nxt);
        M_NUMDOT: begin
          add_token(K_NUM, tok_origin, pos);
          add_token(K_END, pos, nxt);
        end
        default: ;
      endcase
      if (byte_tokens.size() == 0) add_token(K_NONE, 32'd0, 32'd0);
      t      = byte_tokens.pop_back();
      t.last = 1'b1;
      byte_tokens.push_back(t);
      lex_state   = M_IDLE;
      tok_origin  = '0;
      next_offset = '0;
      star_flag   = 1'b0;
    end else begin
      next_offset = nxt;
    end

    foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
  endfunction

  // Count a fault; print only the first ten
  task automatic flag_fault(input string why, input tok_t want, input tok_t got);
    fault_count_o++;
    if (fault_count_o <= 10)
      $display("%0t: %s: expected kind %0d span %0d..%0d last %0d, %s",
               $realtime, why, want.kind, want.span_start, want.span_end, want.last,
               $sformatf("got kind %0d span %0d..%0d last %0d",
                         got.kind, got.span_start, got.span_end, got.last));
  endtask

  // Predict on accepted bytes, compare accepted tokens
  always @(posedge clk_i or negedge rst_ni) begin : watch
    tok_t seen;
    tok_t want;
    if (!rst_ni) begin
      lex_state     = M_IDLE;
      tok_origin    = '0;
      next_offset   = '0;
      star_flag     = 1'b0;
      expected_tokens.delete();
      pending_o     = 0;
      fault_count_o = 0;
    end else begin
      if (in_i.valid && in_i.ready) lex_byte(in_i.ch, in_i.final_byte);
      if (out_i.valid && out_i.ready) begin
        seen.kind       = out_i.kind;
        seen.span_start = out_i.span_start;
        seen.span_end   = out_i.span_end;
        seen.last       = out_i.last;
        if (expected_tokens.size() == 0) begin
          flag_fault("token with none due", '0, seen);
        end else begin
          want = expected_tokens.pop_front();
          if (seen.kind != want.kind || seen.span_start != want.span_start ||
              seen.span_end != want.span_end || seen.last != want.last)
            flag_fault("token mismatch", want, seen);
        end
      end
      pending_o = unsigned'(expected_tokens.size());
    end
  end

endmodule

// ===== tb/logic_language_tokenizer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// logic_language_tokenizer_test: regression for the logic-language tokenizer
// Feeds directed source texts and random texts built from well-formed lexemes
// mixed with noise, under random stalls on both channels and one long output
// hold-off.
// ----------------------------------------------------------------------------
module logic_language_tokenizer_test;
  import llt_pkg::*;

  localparam int unsigned POS_BITS    = POSITION_BITS_DEF;
  localparam int unsigned LONG_HOLD   = 200;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned fault_count;
  int unsigned tokens_pending;
  int unsigned cycle_count;
  int unsigned bytes_sent;
  int unsigned hold_requests;
  logic        jitter_on;
  logic [7:0]  text_q[$];

  llt_in_if  byte_bus ();
  llt_out_if token_bus ();

  logic_language_tokenizer #(
    .POSITION_BITS(POS_BITS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_bus),
    .out_o (token_bus)
  );

  logic_language_tokenizer_checker #(
    .POSITION_BITS(POS_BITS)
  ) token_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (byte_bus),
    .out_i        (token_bus),
    .fault_count_o(fault_count),
    .pending_o    (tokens_pending)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stop a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("logic_language_tokenizer regression: fail");
    $finish;
  end

  // Token receiver: random stall bursts, one long hold-off on request
  initial begin : receiver
    int unsigned holds_done;
    holds_done      = 0;
    token_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_done < hold_requests) begin
        holds_done++;
        token_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end else if (jitter_on && $urandom_range(0, 4) == 0) begin
        token_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk_i);
      end else begin
        token_bus.ready <= 1'b1;
      end
    end
  end

  // Offer one byte and hold it until accepted; start and end on a falling edge
  task automatic offer_byte(input logic [7:0] c, input logic fin);
    if (jitter_on && $urandom_range(0, 5) == 0) begin
      byte_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    byte_bus.valid      <= 1'b1;
    byte_bus.ch         <= c;
    byte_bus.final_byte <= fin;
    @(posedge clk_i);
    while (!byte_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Send the buffered text, marking the last byte as final when asked
  task automatic send_text(input logic close);
    foreach (text_q[i]) offer_byte(text_q[i], close && (i == text_q.size() - 1));
    text_q.delete();
  endtask

  task automatic queue_string(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // Stop sending until every predicted token has come out
  task automatic wait_drained();
    byte_bus.valid <= 1'b0;
    @(negedge clk_i);
    while (tokens_pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [7:0] word_byte();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(8'h41, 8'h5A));
      1:       return 8'($urandom_range(8'h61, 8'h7A));
      2:       return 8'($urandom_range(8'h30, 8'h39));
      default: return CH_UNDERSCORE;
    endcase
  endfunction

  function automatic logic [7:0] pick_symbol();
    case ($urandom_range(0, 14))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      4:       return CH_BSLASH;
      5:       return CH_CARET;
      6:       return CH_LT;
      7:       return CH_GT;
      8:       return CH_EQ;
      9:       return CH_TILDE;
      10:      return CH_COLON;
      11:      return CH_QMARK;
      12:      return CH_AT;
      13:      return CH_HASH;
      default: return CH_AMP;
    endcase
  endfunction

  function automatic logic [7:0] pick_punct();
    case ($urandom_range(0, 7))
      0:       return CH_LPAREN;
      1:       return CH_RPAREN;
      2:       return CH_LBRACK;
      3:       return CH_RBRACK;
      4:       return CH_BAR;
      5:       return CH_COMMA;
      6:       return CH_BANG;
      default: return CH_SEMI;
    endcase
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // Append one random lexeme, mostly well formed, sometimes broken or noise
  task automatic add_lexeme();
    logic [7:0] q;
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: begin
        text_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
        repeat ($urandom_range(0, 3)) text_q.push_back(word_byte());
      end
      1: begin
        text_q.push_back($urandom_range(0, 1) ? CH_UNDERSCORE :
                         8'($urandom_range(8'h41, 8'h5A)));
        repeat ($urandom_range(0, 3)) text_q.push_back(word_byte());
      end
      2: begin
        repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(8'h30, 8'h39)));
        case ($urandom_range(0, 2))
          1: begin
            text_q.push_back(CH_DOT);
            repeat ($urandom_range(1, 2)) text_q.push_back(8'($urandom_range(8'h30, 8'h39)));
          end
          2:       text_q.push_back(CH_DOT);
          default: ;
        endcase
      end
      3: text_q.push_back(pick_punct());
      4: begin
        // Quoted text, left open now and then
        q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        text_q.push_back(q);
        repeat ($urandom_range(0, 3)) begin
          b = 8'($urandom_range(0, 255));
          text_q.push_back((b == q) ? 8'h61 : b);
        end
        if ($urandom_range(0, 7) != 0) text_q.push_back(q);
      end
      5: repeat ($urandom_range(1, 3)) text_q.push_back(pick_symbol());
      6: begin
        if ($urandom_range(0, 1)) begin
          text_q.push_back(CH_PERCENT);
          repeat ($urandom_range(0, 3)) begin
            b = 8'($urandom_range(0, 255));
            text_q.push_back((b == CH_LF) ? 8'h61 : b);
          end
          text_q.push_back(CH_LF);
        end else begin
          text_q.push_back(CH_SLASH);
          text_q.push_back(CH_STAR);
          repeat ($urandom_range(0, 3)) begin
            b = 8'($urandom_range(0, 255));
            text_q.push_back((b == CH_STAR) ? 8'h61 : b);
          end
          text_q.push_back(CH_STAR);
          text_q.push_back(CH_SLASH);
        end
      end
      7: begin
        text_q.push_back(CH_DOT);
        if ($urandom_range(0, 3) == 0) begin
          text_q.push_back(CH_PERCENT);
          text_q.push_back(CH_LF);
        end else begin
          text_q.push_back(pick_blank());
        end
      end
      8:       text_q.push_back(pick_blank());
      default: text_q.push_back(8'($urandom_range(0, 255)));
    endcase
    if ($urandom_range(0, 1)) text_q.push_back(pick_blank());
  endtask

  // Random texts until the byte budget is spent
  task automatic send_random(input int unsigned budget);
    bytes_sent = 0;
    while (bytes_sent < budget) begin
      repeat ($urandom_range(2, 8)) add_lexeme();
      bytes_sent += text_q.size();
      send_text(1'b1);
    end
  endtask

  // Stimulus and verdict
  initial begin
    rst_ni              = 1'b0;
    jitter_on           = 1'b1;
    hold_requests       = 0;
    byte_bus.valid      = 1'b0;
    byte_bus.ch         = '0;
    byte_bus.final_byte = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Every token kind, then a clause end on layout
    queue_string("a(X,[1|_]);!. ");
    send_text(1'b1);
    // Comment that a star-slash inside the opener does not close, number
    // ending at a dropped dot, symbol run from a slash, unclosed quote
    queue_string("/*/*/7.x/+'q");
    send_text(1'b1);
    // Extreme bytes, lone slash, comment left open at the end
    text_q.push_back(8'hFF);
    text_q.push_back(CH_SLASH);
    text_q.push_back(8'h00);
    text_q.push_back(CH_PERCENT);
    send_text(1'b1);
    // Number with its dot on the final byte
    queue_string("9.");
    send_text(1'b1);
    // Text with no token at all
    queue_string("%");
    send_text(1'b1);
    wait_drained();

    // Hold the output while bytes keep coming, so the queue fills up
    hold_requests++;
    repeat (24) text_q.push_back(CH_LPAREN);
    text_q.push_back(CH_RPAREN);
    send_text(1'b1);
    wait_drained();

    // Random texts with stalls, then a stretch with none
    send_random(70);
    wait_drained();
    jitter_on = 1'b0;
    send_random(25);

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (fault_count == 0) begin
      $display("logic_language_tokenizer regression: pass");
    end else begin
      $display("logic_language_tokenizer regression: fail");
    end
    $finish;
  end

endmodule
